// ===== rtl/core/three_channel_abs_moving_average_core_defines.svh =====
// assertion macros shared by the moving average core files
`ifndef THREE_CHANNEL_ABS_MOVING_AVERAGE_CORE_DEFINES_SVH
`define THREE_CHANNEL_ABS_MOVING_AVERAGE_CORE_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/core/tcama_pkg.sv =====
// types, constants and helpers of the three-channel magnitude moving average
`timescale 1ns / 1ps
package tcama_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W = 16;
	localparam int FRAC_W = 4;
	localparam int MEAN_W = 20;
	localparam int USED_W = 5;
	localparam int NCH = 3;
	// quotient bits resolved per divider cycle
	localparam int RADIX_BITS = 2;

	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [MEAN_W-1:0] mean_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// magnitude of a two's complement sample; the most negative code maps to 2^15
	function automatic mag_t magnitude(input logic signed [SAMPLE_W-1:0] s);
		mag_t m;
		if (s[SAMPLE_W-1]) begin
			m = mag_t'(~s) + mag_t'(1);
		end else begin
			m = mag_t'(s);
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/tcama_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tcama_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tcama_div.sv =====
// iterative restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps
`include "three_channel_abs_moving_average_core_defines.svh"
module tcama_div #(
	parameter int DIVISOR_W = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DIVISOR_W-1:0]          rem_init,
	input  logic [tcama_pkg::MEAN_W-1:0]  dividend_lo,
	input  logic [DIVISOR_W-1:0]          divisor,
	output tcama_pkg::div_status_t        status,
	output logic [tcama_pkg::MEAN_W-1:0]  quotient
);
	import tcama_pkg::*;

	localparam int STEPS = MEAN_W / RADIX_BITS;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [MEAN_W-1:0]    acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W-1:0] rem_nxt;
	logic [MEAN_W-1:0]    acc_nxt;

	// radix steps; remainder stays below divisor so the trial value fits one extra bit
	always_comb begin
		logic [DIVISOR_W:0]   t;
		logic [DIVISOR_W-1:0] r;
		logic [MEAN_W-1:0]    a;
		r = rem_q;
		a = acc_q;
		for (int i = 0; i < RADIX_BITS; i++) begin
			t = {r, a[MEAN_W-1]};
			a = {a[MEAN_W-2:0], 1'b0};
			if (t >= {1'b0, divisor_q}) begin
				t = t - {1'b0, divisor_q};
				a[0] = 1'b1;
			end
			r = t[DIVISOR_W-1:0];
		end
		rem_nxt = r;
		acc_nxt = a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= rem_init;
			acc_q     <= dividend_lo;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			acc_q <= acc_nxt;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = acc_q;

	`ASSERT_NEVER(a_start_while_busy, clk, arst_n, start && busy_q)
	`ASSERT_HOLDS(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))
	`ASSERT_HOLDS(a_rem_below_divisor, clk, arst_n, busy_q |-> (rem_q < divisor_q))

endmodule

// ===== rtl/core/three_channel_abs_moving_average_core.sv =====
// top level of the three-channel magnitude moving average with warm-up
//
// input channel: in_valid/in_ready carry one word of three signed 16-bit samples
//   (sample_ch1..3). output channel: out_valid/out_ready carry one word per input
//   word with the three mean magnitudes (mean_ch1..3, LSB units with 4 fraction
//   bits, truncated) and samples_used, the number of samples averaged
// each channel keeps a ring of the last WINDOW magnitudes in one shared ram and a
//   running sum; before the ring is full the mean divides by the words seen so far
// sequence from input accept to out_valid: a ram read state, then per channel a sum
//   update state and a pass through the shared radix-4 divider, then the output
//   register is loaded from the final state
// throughput: a new word is accepted only once the previous one is through, as the single
//   divider serves all three channels in turn; in_ready is high only while the sequencer is idle
// reset: arst_n clears the write index, fill count, sums and output valid; ring
//   contents are left as they are and are never used before being written
// stall: the result sits in the output register until taken; a new word may be
//   accepted meanwhile, and its result waits in the final state until the output
//   register frees up
`timescale 1ns / 1ps
`include "three_channel_abs_moving_average_core_defines.svh"
module three_channel_abs_moving_average_core #(
	parameter int WINDOW = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [tcama_pkg::SAMPLE_W-1:0] sample_ch1,
	input  logic signed [tcama_pkg::SAMPLE_W-1:0] sample_ch2,
	input  logic signed [tcama_pkg::SAMPLE_W-1:0] sample_ch3,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tcama_pkg::MEAN_W-1:0]         mean_ch1,
	output logic [tcama_pkg::MEAN_W-1:0]         mean_ch2,
	output logic [tcama_pkg::MEAN_W-1:0]         mean_ch3,
	output logic [tcama_pkg::USED_W-1:0]         samples_used
);
	import tcama_pkg::*;

	localparam int IDX_W = $clog2(WINDOW);
	localparam int F_W = $clog2(WINDOW + 1);
	// largest sum is WINDOW * 2^15
	localparam int SUM_W = MAG_W + F_W;
	localparam int RAM_W = NCH * MAG_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
	localparam logic [F_W-1:0] WIN_F = F_W'(WINDOW);
	localparam logic [1:0] CH_LAST = 2'(NCH - 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [F_W-1:0]   fill_q;
	logic             full_q;
	logic [1:0]       ch_q;
	logic [SUM_W-1:0] sum_q [NCH];
	mag_t             mag_q [NCH];
	mean_t            res_q [NCH];
	logic             out_valid_q;
	mean_t            mean1_q, mean2_q, mean3_q;
	logic [USED_W-1:0] used_q;

	logic             in_acc;
	logic             out_load;
	logic [RAM_W-1:0] ram_wdata;
	logic [RAM_W-1:0] ram_rdata;
	mag_t             old_mag;
	mag_t             sub_mag;
	logic [SUM_W-1:0] new_sum;
	logic             div_start;
	div_status_t      div_stat;
	mean_t            div_quot;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign ram_wdata = {mag_q[2], mag_q[1], mag_q[0]};

	// ring storage, one row holds all three channels
	tcama_ram #(
		.WIDTH(RAM_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == S_READ),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// shared adder: drop the overwritten entry once the ring is full, add the new one
	assign old_mag   = ram_rdata[ch_q*MAG_W +: MAG_W];
	assign sub_mag   = full_q ? old_mag : '0;
	assign new_sum   = sum_q[ch_q] - SUM_W'(sub_mag) + SUM_W'(mag_q[ch_q]);
	assign div_start = (state_q == S_SUM);

	// dividend is sum * 16; its bits above the quotient width start as the remainder
	tcama_div #(
		.DIVISOR_W(F_W)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.rem_init   (new_sum[SUM_W-1:MAG_W]),
		.dividend_lo({new_sum[MAG_W-1:0], {FRAC_W{1'b0}}}),
		.divisor    (fill_q),
		.status     (div_stat),
		.quotient   (div_quot)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			fill_q      <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					idx_q  <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
					if (!full_q) begin
						fill_q <= fill_q + F_W'(1);
					end
					ch_q    <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q[ch_q] <= new_sum;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (ch_q == CH_LAST) begin
							state_q <= S_DONE;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= S_SUM;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q[0] <= magnitude(sample_ch1);
			mag_q[1] <= magnitude(sample_ch2);
			mag_q[2] <= magnitude(sample_ch3);
			full_q   <= (fill_q == WIN_F);
		end
		if (state_q == S_DIV && div_stat.done) begin
			res_q[ch_q] <= div_quot;
		end
		if (out_load) begin
			mean1_q <= res_q[0];
			mean2_q <= res_q[1];
			mean3_q <= res_q[2];
			used_q  <= USED_W'(fill_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign mean_ch1     = mean1_q;
	assign mean_ch2     = mean2_q;
	assign mean_ch3     = mean3_q;
	assign samples_used = used_q;

	`ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > WIN_F)
	`ASSERT_HOLDS(a_warmup_index, clk, arst_n, (fill_q != WIN_F) |-> (idx_q == fill_q[IDX_W-1:0]))
	`ASSERT_HOLDS(a_accept_busy, clk, arst_n, in_acc |=> (!in_ready && state_q == S_READ))
	`ASSERT_NEVER(a_div_done_state, clk, arst_n, div_stat.done && state_q != S_DIV)

endmodule
